/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the session frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;
  localparam int LOGIN_PAYLOAD_BYTES = 46;
  localparam int CREDENTIAL_BYTES    = 26;
  localparam int CRED_AW             = 5;

  localparam logic [63:0] TIMEOUT_RESET   = 64'd15000000000;
  localparam logic [63:0] HEARTBEAT_RESET = 64'd1000000000;

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_ACCEPT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_LOGIN_BYTE = 3'd0,
    EV_REJECT     = 3'd1,
    EV_UNSEQ      = 3'd2,
    EV_LOGOUT     = 3'd3,
    EV_TIMEOUT    = 3'd4,
    EV_HEARTBEAT  = 3'd5,
    EV_ACCEPTED   = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    SP_AWAIT  = 2'd0,
    SP_LOGGED = 2'd1,
    SP_CLOSED = 2'd2
  } sess_t;

  typedef enum logic [1:0] {
    FP_LEN_HI  = 2'd0,
    FP_LEN_LO  = 2'd1,
    FP_TYPE    = 2'd2,
    FP_PAYLOAD = 2'd3
  } frame_t;

  typedef enum logic [1:0] {
    QP_LEAD  = 2'd0,
    QP_DIGIT = 2'd1,
    QP_TRAIL = 2'd2
  } seqp_t;

  typedef enum logic [1:0] {
    CS_IDLE  = 2'd0,
    CS_READ  = 2'd1,
    CS_BURST = 2'd2
  } ctl_t;

  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_HEARTBEAT = 1'b1;
endpackage

/* design/session_frame_receiver.sv */
// ----------------------------------------------------------------------------
// session_frame_receiver
// Receive side of a length-prefixed server session: deframing, login capture
// and sequence parsing, unsequenced forwarding, timeout and heartbeat checks.
// ----------------------------------------------------------------------------
// Takes one word per cycle for stream bytes, ticks and accepts, while no
// credential burst runs and the output is not stalled; each produces at most
// one result word, registered at the output. The end of a good login packet
// plays the 26 stored credential bytes out of the credential RAM, after a
// CS_READ state, at one per cycle while the output is not stalled. Input is
// held off from the accepting edge until the 26th byte has left the output
// register. The sequence digit multiply-by-ten is done as shift-add.
module session_frame_receiver
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic [63:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        empty_res,
  output logic [63:0] login_seq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] session_timeout, heartbeat_interval;
  sess_t       session_phase;
  logic [63:0] last_receive_time, last_send_time;
  frame_t      frame_phase;
  logic [15:0] bytes_left;
  logic [7:0]  packet_kind;
  logic        deframer_stalled;
  logic [63:0] seq_accumulator;
  seqp_t       seq_parse_phase;
  logic        seq_invalid;
  logic [5:0]  payload_index;

  logic [7:0]  cred_mem [CREDENTIAL_BYTES];
  logic [7:0]  cred_rd;
  logic [CRED_AW-1:0] rd_addr;
  ctl_t        ctl, ctl_next;

  // one-result staging
  logic        r_en;
  event_t      r_ev;
  logic [7:0]  r_byte;
  logic        r_last, r_empty;
  logic        start_burst;

  logic        out_free, take;
  logic [63:0] rx_diff, tx_diff;
  logic        is_digit, is_space;
  logic [63:0] acc_x10;
  logic [15:0] left_dec;
  logic        at_last_rd;

  logic        burst_shown;
  logic [CRED_AW-1:0] burst_idx;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (ctl == CS_IDLE) && !burst_shown && out_free;
  assign take      = in_valid && in_ready;
  assign rx_diff   = now_time - last_receive_time;
  assign tx_diff   = now_time - last_send_time;
  assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign is_space  = (data_byte == CH_SPACE);
  assign acc_x10   = (seq_accumulator << 3) + (seq_accumulator << 1)
                     + {56'd0, data_byte - CH_0};
  assign left_dec  = bytes_left - 16'd1;
  assign at_last_rd = (rd_addr == CRED_AW'(CREDENTIAL_BYTES - 1));

  // result decode for one input word
  always_comb begin
    r_en = 1'b0; r_ev = EV_LOGIN_BYTE; r_byte = 8'd0; r_last = 1'b0; r_empty = 1'b0;
    start_burst = 1'b0;
    case (mode_t'(mode))
      MODE_BYTE: begin
        if (session_phase != SP_CLOSED && !deframer_stalled) begin
          if (frame_phase == FP_TYPE && bytes_left == 16'd1) begin
            if (session_phase == SP_LOGGED && data_byte == CH_U) begin
              r_en = 1'b1; r_ev = EV_UNSEQ; r_last = 1'b1; r_empty = 1'b1;
            end else if (session_phase == SP_AWAIT && data_byte == CH_L) begin
              r_en = 1'b1; r_ev = EV_REJECT; r_byte = CH_A;
            end else if (session_phase == SP_LOGGED && data_byte == CH_O) begin
              r_en = 1'b1; r_ev = EV_LOGOUT;
            end
          end else if (frame_phase == FP_PAYLOAD) begin
            if (session_phase == SP_LOGGED && packet_kind == CH_U) begin
              r_en = 1'b1; r_ev = EV_UNSEQ; r_byte = data_byte;
              r_last = (bytes_left == 16'd1);
            end else if (bytes_left == 16'd1) begin
              if (session_phase == SP_AWAIT && packet_kind == CH_L) begin
                // final byte is the last sequence char when size is right
                if (payload_index == 6'(LOGIN_PAYLOAD_BYTES - 1) && !seq_invalid &&
                    !(seq_parse_phase == QP_LEAD && !is_digit && !is_space) &&
                    !(seq_parse_phase == QP_DIGIT && !is_digit && !is_space) &&
                    !(seq_parse_phase == QP_TRAIL && !is_space)) begin
                  start_burst = 1'b1;
                end else begin
                  r_en = 1'b1; r_ev = EV_REJECT; r_byte = CH_A;
                end
              end else if (session_phase == SP_LOGGED && packet_kind == CH_O) begin
                r_en = 1'b1; r_ev = EV_LOGOUT;
              end
            end
          end
        end
      end
      MODE_TICK: begin
        if (session_phase != SP_CLOSED) begin
          if (rx_diff >= session_timeout) begin
            r_en = 1'b1; r_ev = EV_TIMEOUT;
          end else if (session_phase == SP_LOGGED && tx_diff >= heartbeat_interval) begin
            r_en = 1'b1; r_ev = EV_HEARTBEAT;
          end
        end
      end
      MODE_ACCEPT: begin
        r_en = 1'b1; r_ev = EV_ACCEPTED;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl_next = ctl;
    case (ctl)
      CS_IDLE:  if (take && start_burst) ctl_next = CS_READ;
      CS_READ:  ctl_next = CS_BURST;
      CS_BURST: if (out_free && at_last_rd) ctl_next = CS_IDLE;
      default:  ctl_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) ctl <= CS_IDLE;
    else     ctl <= ctl_next;
  end

  // credential RAM
  always_ff @(posedge clk) begin
    if (take && mode_t'(mode) == MODE_BYTE && session_phase == SP_AWAIT &&
        !deframer_stalled && frame_phase == FP_PAYLOAD && packet_kind == CH_L &&
        payload_index < 6'(CREDENTIAL_BYTES))
      cred_mem[payload_index[CRED_AW-1:0]] <= data_byte;
    if (ctl == CS_READ || (ctl == CS_BURST && out_free))
      cred_rd <= cred_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (ctl == CS_READ) begin
      rd_addr <= CRED_AW'(1);
    end else if (ctl == CS_BURST && out_free) begin
      rd_addr <= at_last_rd ? '0 : rd_addr + CRED_AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      burst_shown <= 1'b0;
      burst_idx   <= '0;
    end else if (ctl == CS_BURST && out_free && !burst_shown) begin
      out_valid <= 1'b1; burst_shown <= 1'b1; burst_idx <= '0;
      event_res <= EV_LOGIN_BYTE; out_byte <= cred_rd;
      last <= 1'b0; empty_res <= 1'b0; login_seq <= '0;
    end else if (burst_shown && out_free) begin
      if (burst_idx == CRED_AW'(CREDENTIAL_BYTES - 1)) begin
        out_valid <= 1'b0; burst_shown <= 1'b0;
      end else begin
        burst_idx <= burst_idx + CRED_AW'(1);
        event_res <= EV_LOGIN_BYTE; out_byte <= cred_rd;
        last <= (burst_idx == CRED_AW'(CREDENTIAL_BYTES - 2));
        empty_res <= 1'b0;
        login_seq <= (burst_idx == CRED_AW'(CREDENTIAL_BYTES - 2)) ?
                     seq_accumulator : '0;
      end
    end else if (out_free) begin
      out_valid <= take && r_en;
      event_res <= r_ev; out_byte <= r_byte; last <= r_last;
      empty_res <= r_empty; login_seq <= '0;
    end
  end

  // session and deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      session_timeout    <= TIMEOUT_RESET;
      heartbeat_interval <= HEARTBEAT_RESET;
      session_phase      <= SP_AWAIT;
      last_receive_time  <= '0;
      last_send_time     <= '0;
      frame_phase        <= FP_LEN_HI;
      bytes_left         <= '0;
      packet_kind        <= '0;
      deframer_stalled   <= 1'b0;
      seq_accumulator    <= '0;
      seq_parse_phase    <= QP_LEAD;
      seq_invalid        <= 1'b0;
      payload_index      <= '0;
    end else begin
      if (cfg_valid && cfg_index == 64'(CFG_TIMEOUT)) session_timeout <= cfg_data;
      if (cfg_valid && cfg_index == 64'(CFG_HEARTBEAT)) heartbeat_interval <= cfg_data;
      if (take) begin
        case (mode_t'(mode))
          MODE_BYTE: if (session_phase != SP_CLOSED) begin
            last_receive_time <= now_time;
            if (!deframer_stalled) begin
              case (frame_phase)
                FP_LEN_HI: begin
                  bytes_left <= {data_byte, 8'd0};
                  frame_phase <= FP_LEN_LO;
                end
                FP_LEN_LO: begin
                  bytes_left <= bytes_left | {8'd0, data_byte};
                  if ((bytes_left | {8'd0, data_byte}) == 16'd0) deframer_stalled <= 1'b1;
                  else frame_phase <= FP_TYPE;
                end
                FP_TYPE: begin
                  packet_kind <= data_byte;
                  bytes_left <= left_dec;
                  payload_index <= '0;
                  seq_accumulator <= '0;
                  seq_parse_phase <= QP_LEAD;
                  seq_invalid <= 1'b0;
                  frame_phase <= (left_dec == 16'd0) ? FP_LEN_HI : FP_PAYLOAD;
                  if (left_dec == 16'd0 && r_en &&
                      (r_ev == EV_REJECT || r_ev == EV_LOGOUT))
                    session_phase <= SP_CLOSED;
                end
                default: begin
                  bytes_left <= left_dec;
                  if (session_phase == SP_AWAIT && packet_kind == CH_L &&
                      payload_index >= 6'(CREDENTIAL_BYTES) &&
                      payload_index < 6'(LOGIN_PAYLOAD_BYTES)) begin
                    case (seq_parse_phase)
                      QP_LEAD: begin
                        if (is_digit) begin
                          seq_parse_phase <= QP_DIGIT;
                          seq_accumulator <= {56'd0, data_byte - CH_0};
                        end else if (!is_space) seq_invalid <= 1'b1;
                      end
                      QP_DIGIT: begin
                        if (is_digit) seq_accumulator <= acc_x10;
                        else if (is_space) seq_parse_phase <= QP_TRAIL;
                        else seq_invalid <= 1'b1;
                      end
                      default: if (!is_space) seq_invalid <= 1'b1;
                    endcase
                  end
                  if (payload_index != 6'd63) payload_index <= payload_index + 6'd1;
                  if (left_dec == 16'd0) begin
                    frame_phase <= FP_LEN_HI;
                    if (r_en && (r_ev == EV_REJECT || r_ev == EV_LOGOUT))
                      session_phase <= SP_CLOSED;
                  end
                end
              endcase
            end
          end
          MODE_TICK: if (session_phase != SP_CLOSED) begin
            if (rx_diff >= session_timeout) session_phase <= SP_CLOSED;
            else if (session_phase == SP_LOGGED && tx_diff >= heartbeat_interval)
              last_send_time <= now_time;
          end
          MODE_ACCEPT: session_phase <= SP_LOGGED;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) (ctl != CS_IDLE) |-> !in_ready)
    else $error("input taken during credential burst");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && event_res == EV_LOGIN_BYTE) |-> burst_shown)
    else $error("stray final login byte");
  assert property (@(posedge clk) disable iff (rst)
    (take && mode_t'(mode) == MODE_ACCEPT) |=> session_phase == SP_LOGGED)
    else $error("accept did not log in");
endmodule
